[hdl/dts_pkg.sv]
// Shared types, sizes and helpers of the dependency scheduler.
// Used by the channel interfaces, the top level and the checker; no dependencies.
package dts_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NODE_W  = 6;
  localparam int CFG_W   = 7;
  localparam int NIDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int ETOT_W  = $clog2(MAX_EDGES + 1);
  localparam int PEND_W  = ETOT_W;
  localparam int EDGE_DW = 2 * NODE_W;
  localparam int PADDR_W = 3;
  localparam int APB_DW  = 32;

  localparam logic [0:0] REG_NODES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] NODES_RESET = CFG_W'(1);

  typedef struct packed {
    logic              has_edge;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic              last_edge;
  } dts_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              order_end;
    logic              all_scheduled;
    logic              empty_order;
    logic              edges_dropped;
  } dts_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WAIT,
    ST_SCAN,
    ST_POP,
    ST_FETCH,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } dts_state_t;

  // Clamp the node count register to the supported range.
  function automatic logic [CFG_W-1:0] active_nodes(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] n;
    n = cfg;
    if (cfg == '0) begin
      n = CFG_W'(1);
    end else if (cfg > CFG_W'(MAX_NODES)) begin
      n = CFG_W'(MAX_NODES);
    end
    return n;
  endfunction

endpackage

[hdl/dts_in_if.sv]
// Edge input channel: valid/ready handshake carrying one dependency edge.
// Depends on dts_pkg for the payload type.
interface dts_in_if;
  logic              valid;
  logic              ready;
  dts_pkg::dts_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input ready, input data);
endinterface

[hdl/dts_out_if.sv]
// Order output channel: valid/ready handshake carrying one scheduled node.
// Depends on dts_pkg for the payload type.
interface dts_out_if;
  logic              valid;
  logic              ready;
  dts_pkg::dts_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input ready, input data);
endinterface

[hdl/dependency_topological_scheduler_unit.sv]
// Top level of the dependency scheduler: edge loading and Kahn topological sort.
// Depends on dts_pkg, dts_in_if and dts_out_if.
//
//   channel   direction  payload                                      transfer when
//   edges     in         has_edge, source_node, target_node, last_edge valid & ready
//   order     out        node_index, order_end, all_scheduled,        valid & ready
//                        empty_order, edges_dropped
//   apb       in/out     nodes_in_use at byte address 0                psel & penable & pwrite
//
// Edges load at one per cycle. After the last edge the block passes a settling state and
// then scans every active node for nodes with no dependency. Each dequeued node is fetched
// and, if edges are stored, walks the whole edge list at one edge memory read per cycle and
// drains; the run ends with a pop that finds the queue empty and a final result state.
// No clearing pass after reset: the pending counts carry one valid bit per node.
// The edge input stalls until the final result is registered; a stalled result stalls
// the walk only when a second result is ready to move up.

module dependency_topological_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  dts_in_if.sink                        edges,
  dts_out_if.source                     order,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dts_pkg::PADDR_W-1:0]   paddr,
  input  logic [dts_pkg::APB_DW-1:0]    pwdata,
  output logic [dts_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int NODE_W  = dts_pkg::NODE_W;
  localparam int CFG_W   = dts_pkg::CFG_W;
  localparam int NIDX_W  = dts_pkg::NIDX_W;
  localparam int CNT_W   = dts_pkg::CNT_W;
  localparam int EDGE_AW = dts_pkg::EDGE_AW;
  localparam int ETOT_W  = dts_pkg::ETOT_W;
  localparam int PEND_W  = dts_pkg::PEND_W;
  localparam int EDGE_DW = dts_pkg::EDGE_DW;

  // Configuration register.
  logic [CFG_W-1:0] nodes_in_use;
  logic [CFG_W-1:0] n_act;

  assign n_act  = dts_pkg::active_nodes(nodes_in_use);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dts_pkg::REG_NODES_IN_USE) ?
                  dts_pkg::APB_DW'(nodes_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use <= dts_pkg::NODES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dts_pkg::REG_NODES_IN_USE) begin
      nodes_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // Memories: the edge list, the pending count per node and the ready queue.
  logic [EDGE_DW-1:0] edge_mem [dts_pkg::MAX_EDGES];
  logic [PEND_W-1:0]  pend_mem [dts_pkg::MAX_NODES];
  logic [NODE_W-1:0]  fifo_mem [dts_pkg::MAX_NODES];

  logic [EDGE_DW-1:0]          edge_rd;
  logic [PEND_W-1:0]           pend_rd;
  logic [NODE_W-1:0]           fifo_rd;
  logic [dts_pkg::MAX_NODES-1:0] pend_valid;

  // Run state.
  dts_pkg::dts_state_t state, state_next;
  logic [ETOT_W-1:0] edge_total;
  logic [ETOT_W-1:0] edge_ptr;
  logic [CNT_W-1:0]  fifo_head;
  logic [CNT_W-1:0]  fifo_tail;
  logic [CNT_W-1:0]  sched_count;
  logic [CNT_W-1:0]  scan_idx;
  logic              overflow_seen;
  logic              held_valid;
  logic [NODE_W-1:0] held_node;
  logic [NODE_W-1:0] cur_node;

  // Walk pipeline: stage B holds an edge read, stage C updates a pending count.
  logic              b_valid;
  logic              c_valid;
  logic              c_inc;
  logic [NIDX_W-1:0] c_addr;
  logic              fw_valid;
  logic [NIDX_W-1:0] fw_addr;
  logic [PEND_W-1:0] fw_data;

  // Output register.
  logic              out_valid;
  dts_pkg::dts_out_t out_data;

  // Control strobes from the sequencer.
  logic in_fire, load_ok, load_edge, load_drop;
  logic out_free, pop_issue, fetch_take, walk_issue, fin_take;
  logic b_match, c_write, c_push, scan_push, fifo_push;
  logic [PEND_W-1:0] c_cur, c_new;
  logic [NIDX_W-1:0] pend_raddr;
  logic [NODE_W-1:0] fifo_wdata;

  assign edges.ready = (state == dts_pkg::ST_LOAD);
  assign in_fire     = edges.valid && edges.ready;
  assign load_ok     = edges.data.has_edge &&
                       ({1'b0, edges.data.source_node} < n_act) &&
                       ({1'b0, edges.data.target_node} < n_act);
  assign load_edge   = in_fire && load_ok && (edge_total < ETOT_W'(dts_pkg::MAX_EDGES));
  assign load_drop   = in_fire && load_ok && !(edge_total < ETOT_W'(dts_pkg::MAX_EDGES));

  assign out_free    = !out_valid || order.ready;

  // An edge matters to the walk when it leaves the current node and its target is
  // still inside the node count.
  assign b_match = b_valid && (edge_rd[EDGE_DW-1:NODE_W] == cur_node) &&
                   ({1'b0, edge_rd[NODE_W-1:0]} < n_act);

  assign pend_raddr = (state == dts_pkg::ST_LOAD) ?
                      edges.data.target_node[NIDX_W-1:0] : edge_rd[NIDX_W-1:0];

  // The count written last cycle is not yet visible in the read data: forward it.
  always_comb begin
    if (fw_valid && fw_addr == c_addr) begin
      c_cur = fw_data;
    end else if (pend_valid[c_addr]) begin
      c_cur = pend_rd;
    end else begin
      c_cur = '0;
    end
    c_new = c_inc ? (c_cur + PEND_W'(1)) : (c_cur - PEND_W'(1));
  end

  assign c_write   = c_valid && (c_inc || c_cur != '0);
  assign c_push    = c_valid && !c_inc && (c_cur == PEND_W'(1));
  assign scan_push = (state == dts_pkg::ST_SCAN) && !pend_valid[scan_idx[NIDX_W-1:0]];
  assign fifo_push = (scan_push || c_push) && (fifo_tail < CNT_W'(dts_pkg::MAX_NODES));
  assign fifo_wdata = scan_push ? NODE_W'(scan_idx) : NODE_W'(c_addr);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dts_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_issue  = 1'b0;
    fetch_take = 1'b0;
    walk_issue = 1'b0;
    fin_take   = 1'b0;
    unique case (state)
      dts_pkg::ST_LOAD: begin
        if (in_fire && edges.data.last_edge) begin
          state_next = dts_pkg::ST_WAIT;
        end
      end
      dts_pkg::ST_WAIT: begin
        // The last edge's count update lands in this cycle.
        state_next = dts_pkg::ST_SCAN;
      end
      dts_pkg::ST_SCAN: begin
        if (CFG_W'(scan_idx) == n_act - CFG_W'(1)) begin
          state_next = dts_pkg::ST_POP;
        end
      end
      dts_pkg::ST_POP: begin
        if (fifo_head < fifo_tail) begin
          pop_issue  = 1'b1;
          state_next = dts_pkg::ST_FETCH;
        end else begin
          state_next = dts_pkg::ST_FINISH;
        end
      end
      dts_pkg::ST_FETCH: begin
        if (!held_valid || out_free) begin
          fetch_take = 1'b1;
          if (edge_total == '0) begin
            state_next = dts_pkg::ST_POP;
          end else begin
            state_next = dts_pkg::ST_WALK;
          end
        end
      end
      dts_pkg::ST_WALK: begin
        walk_issue = 1'b1;
        if (edge_ptr == edge_total - ETOT_W'(1)) begin
          state_next = dts_pkg::ST_DRAIN;
        end
      end
      dts_pkg::ST_DRAIN: begin
        if (!b_valid && !c_valid) begin
          state_next = dts_pkg::ST_POP;
        end
      end
      dts_pkg::ST_FINISH: begin
        if (out_free) begin
          fin_take   = 1'b1;
          state_next = dts_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = dts_pkg::ST_LOAD;
      end
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (load_edge) begin
      edge_mem[edge_total[EDGE_AW-1:0]] <= {edges.data.source_node, edges.data.target_node};
    end
    if (walk_issue) begin
      edge_rd <= edge_mem[edge_ptr[EDGE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    pend_rd <= pend_mem[pend_raddr];
    if (c_write) begin
      pend_mem[c_addr] <= c_new;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[fifo_tail[NIDX_W-1:0]] <= fifo_wdata;
    end
    if (pop_issue) begin
      fifo_rd <= fifo_mem[fifo_head[NIDX_W-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= '0;
      edge_total    <= '0;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      sched_count   <= '0;
      overflow_seen <= 1'b0;
      held_valid    <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      fw_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      b_valid  <= walk_issue;
      c_valid  <= load_edge || b_match;
      fw_valid <= c_write;
      if (c_write) begin
        pend_valid[c_addr] <= 1'b1;
      end
      if (load_edge) begin
        edge_total <= edge_total + ETOT_W'(1);
      end
      if (load_drop) begin
        overflow_seen <= 1'b1;
      end
      if (fifo_push) begin
        fifo_tail <= fifo_tail + CNT_W'(1);
      end
      if (pop_issue) begin
        fifo_head   <= fifo_head + CNT_W'(1);
        sched_count <= sched_count + CNT_W'(1);
      end
      if (fetch_take) begin
        held_valid <= 1'b1;
      end

      if ((fetch_take && held_valid) || fin_take) begin
        out_valid <= 1'b1;
      end else if (order.ready) begin
        out_valid <= 1'b0;
      end

      // End of the run: every count goes back to zero.
      if (fin_take) begin
        pend_valid    <= '0;
        edge_total    <= '0;
        fifo_head     <= '0;
        fifo_tail     <= '0;
        sched_count   <= '0;
        overflow_seen <= 1'b0;
        held_valid    <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fw_addr <= c_addr;
    fw_data <= c_new;
    if (load_edge) begin
      c_addr <= edges.data.target_node[NIDX_W-1:0];
      c_inc  <= 1'b1;
    end else if (b_match) begin
      c_addr <= edge_rd[NIDX_W-1:0];
      c_inc  <= 1'b0;
    end
    if (state == dts_pkg::ST_LOAD) begin
      scan_idx <= '0;
    end else if (state == dts_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (fetch_take) begin
      held_node <= fifo_rd;
      cur_node  <= fifo_rd;
      edge_ptr  <= '0;
    end else if (walk_issue) begin
      edge_ptr <= edge_ptr + ETOT_W'(1);
    end

    // A held node moves out as an ordinary result once the next one is dequeued;
    // the last one goes out with the run flags.
    if (fetch_take && held_valid) begin
      out_data.node_index    <= held_node;
      out_data.order_end     <= 1'b0;
      out_data.all_scheduled <= 1'b0;
      out_data.empty_order   <= 1'b0;
      out_data.edges_dropped <= 1'b0;
    end else if (fin_take) begin
      out_data.node_index    <= held_valid ? held_node : '0;
      out_data.order_end     <= 1'b1;
      out_data.all_scheduled <= held_valid && (CFG_W'(sched_count) == n_act);
      out_data.empty_order   <= !held_valid;
      out_data.edges_dropped <= overflow_seen;
    end
  end

  assign order.valid = out_valid;
  assign order.data  = out_data;

endmodule

[hdl/dts_checker.sv]
// Port-level checks of the dependency scheduler, bound to its top level.
// Depends on dts_pkg, dts_in_if, dts_out_if and dependency_topological_scheduler_unit.
module dts_checker (
  input logic       clk,
  input logic       rst,
  dts_in_if.sink    edges,
  dts_out_if.source order
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    order.valid && !order.ready |=> order.valid && $stable(order.data))
    else $error("result changed or vanished while stalled");

  a_flags_only_at_end: assert property (@(posedge clk) disable iff (rst)
    order.valid && !order.data.order_end |->
      !order.data.all_scheduled && !order.data.empty_order && !order.data.edges_dropped)
    else $error("run flags set on a result that does not end the order");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    order.valid && order.data.empty_order |->
      order.data.order_end && !order.data.all_scheduled && order.data.node_index == '0)
    else $error("empty order result is malformed");

  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.ready && edges.data.last_edge |=> !edges.ready)
    else $error("edge input still open after the last edge");

endmodule

bind dependency_topological_scheduler_unit dts_checker u_dts_checker (
  .clk   (clk),
  .rst   (rst),
  .edges (edges),
  .order (order)
);
